// ===== hw/rtl/cdps_pkg.sv =====
// ----------------------------------------------------------------------------
// cdps_pkg: shared types for the CDP offset stack
// Datapath command and status structs.
// ----------------------------------------------------------------------------
package cdps_pkg;

    typedef struct packed {
        logic load_in;    // capture input item
        logic mem_rd;     // read accumulator entry
        logic div_start;  // start divide of read entry
        logic mem_wr;     // write accumulator entry
        logic out_load;   // load output register
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic emit;       // item yields a result
        logic out_busy;
    } t_status;

endpackage

// ===== hw/rtl/cdps_div.sv =====
// ----------------------------------------------------------------------------
// cdps_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module cdps_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW:0]   o_quo
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_sh;
    logic [DW-1:0] w_mag;

    assign w_mag   = i_num[DW-1] ? (~i_num + 1'b1) : i_num;
    assign w_sh    = {r_rem[DW-1:0], r_q[DW-1]};
    assign w_trial = w_sh - {1'b0, r_den};

    always_comb begin
        n_q   = {r_q[DW-2:0], 1'b0};
        n_rem = w_sh;
        if (!w_trial[DW]) begin
            n_rem = w_trial;
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_q    <= w_mag;
                r_rem  <= '0;
                r_den  <= DW'(i_den);
                r_neg  <= i_num[DW-1];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? (~{1'b0, r_q} + 1'b1) : {1'b0, r_q};
endmodule

// ===== hw/rtl/cdps_datapath.sv =====
// ----------------------------------------------------------------------------
// cdps_datapath: gather state, accumulator memory, divider and output
// Holds the stacking state and produces the read-out items.
// ----------------------------------------------------------------------------
module cdps_datapath #(
    parameter int NUM_SAMPLES = 4096,
    parameter int MAX_FOLD    = 255,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cdps_pkg::t_cmd         i_cmd,
    output cdps_pkg::t_status      o_sts,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [19:0]            i_cfg_data,
    input  logic                   i_operation,
    input  logic [23:0]            i_cdp_number,
    input  logic signed [19:0]     i_trace_offset,
    input  logic [11:0]            i_sample_index,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [23:0]            o_stack_cdp,
    output logic [7:0]             o_stack_fold,
    output logic [11:0]            o_out_index,
    output logic signed [SAMPLE_BITS-1:0] o_stack_value,
    output logic                   o_out_last
);
    localparam int AW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int FW = $clog2(MAX_FOLD + 1);
    localparam logic signed [33:0] HI = 34'sd1 <<< (SAMPLE_BITS - 1);

    logic signed [19:0] r_min, r_max;
    logic [23:0] r_cur_cdp, r_drain_cdp;
    logic        r_valid_g, r_draining, r_incl;
    logic [FW-1:0] r_fold, r_drain_fold;

    logic        r_op, r_last, r_ovr;
    logic [11:0] r_idx;
    logic signed [SAMPLE_BITS-1:0] r_val;
    logic [AW-1:0] w_addr;
    logic        w_in_range;

    logic signed [31:0] r_mem [NUM_SAMPLES];
    logic signed [31:0] r_rd;
    logic        r_emit;
    logic [23:0] r_e_cdp;
    logic [FW-1:0] r_e_fold;

    logic        w_div_done;
    logic [32:0] w_quo;
    logic signed [33:0] w_q, w_sum;

    assign w_addr     = AW'(r_idx);
    assign w_in_range = 32'(r_idx) < NUM_SAMPLES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= 20'sd524287;
            r_cur_cdp <= '0;
            r_drain_cdp <= '0;
            r_valid_g <= 1'b0;
            r_draining <= 1'b0;
            r_incl <= 1'b0;
            r_fold <= '0;
            r_drain_fold <= '0;
            r_emit <= 1'b0;
            r_ovr <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (!i_cfg_addr) r_min <= i_cfg_data;
                else r_max <= i_cfg_data;
            end
            if (i_cmd.load_in) begin
                logic          v_g, v_dr, v_inc;
                logic [FW-1:0] v_f, v_df;
                logic [23:0]   v_dc;
                v_g = r_valid_g; v_dr = r_draining; v_f = r_fold;
                v_df = r_drain_fold; v_dc = r_drain_cdp; v_inc = r_incl;
                r_op <= i_operation;
                r_idx <= i_sample_index;
                r_val <= i_sample_value;
                r_last <= i_last_sample;
                if (!i_operation) begin
                    if (i_sample_index == '0) begin
                        if (!r_valid_g || i_cdp_number != r_cur_cdp) begin
                            v_dc = r_cur_cdp;
                            v_df = r_valid_g ? r_fold : '0;
                            v_dr = 1'b1;
                            r_cur_cdp <= i_cdp_number;
                            v_g = 1'b1;
                            v_f = '0;
                        end
                        v_inc = i_trace_offset >= r_min && i_trace_offset <= r_max &&
                                32'(v_f) < MAX_FOLD;
                        if (v_inc) v_f = v_f + 1'b1;
                    end
                    r_emit  <= v_g && 32'(i_sample_index) < NUM_SAMPLES && v_dr &&
                               v_df != '0;
                    r_e_cdp <= v_dc;
                    r_e_fold <= v_df;
                    r_ovr <= v_dr;
                    r_draining <= v_dr;
                    if (i_last_sample) r_draining <= 1'b0;
                    r_valid_g <= v_g; r_fold <= v_f; r_drain_fold <= v_df;
                    r_drain_cdp <= v_dc; r_incl <= v_inc;
                end else begin
                    r_emit <= r_valid_g && r_fold != '0 &&
                              32'(i_sample_index) < NUM_SAMPLES;
                    r_e_cdp <= r_cur_cdp;
                    r_e_fold <= r_fold;
                    r_ovr <= 1'b0;
                    if (i_last_sample) begin
                        r_valid_g <= 1'b0; r_fold <= '0;
                        r_draining <= 1'b0; r_incl <= 1'b0;
                    end
                end
            end
        end
    end

    // pending write: op 0, gather open, in range
    assign w_sum = 34'(r_rd) + 34'(r_val);
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) r_rd <= r_mem[w_addr];
        if (i_cmd.mem_wr && !r_op && r_valid_g && w_in_range) begin
            if (r_ovr)
                r_mem[w_addr] <= r_incl ? 32'(r_val) : 32'sd0;
            else if (r_incl)
                r_mem[w_addr] <= (w_sum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                                 (w_sum < -34'sh80000000) ? 32'sh80000000 : w_sum[31:0];
        end
    end

    cdps_div #(.DW(32), .VW(FW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_rd), .i_den(r_e_fold), .o_done(w_div_done), .o_quo(w_quo)
    );

    assign w_q = 34'(signed'(w_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
                o_stack_cdp <= r_e_cdp;
                o_stack_fold <= 8'(r_e_fold);
                o_out_index <= r_idx;
                o_out_last <= r_last;
                o_stack_value <= (w_q >= HI) ? SAMPLE_BITS'(HI - 1) :
                                 (w_q < -HI) ? SAMPLE_BITS'(-HI) : SAMPLE_BITS'(w_q);
            end
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.emit     = r_emit;
    assign o_sts.out_busy = o_valid && i_stall;
endmodule

// ===== hw/rtl/cdps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdps_ctrl: sequencer for the CDP offset stack
// Accept, read, divide and emit when the item yields a result, write back.
// ----------------------------------------------------------------------------
module cdps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output cdps_pkg::t_cmd    o_cmd,
    input  cdps_pkg::t_status i_sts
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_DIV, S_WAIT, S_OUT, S_WR} t_state;
    t_state r_state;

    assign o_stall = r_state != S_IDLE;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_in   = r_state == S_IDLE && i_valid;
        o_cmd.mem_rd    = r_state == S_RD;
        o_cmd.div_start = r_state == S_DIV;
        o_cmd.out_load  = r_state == S_OUT && !i_sts.out_busy;
        o_cmd.mem_wr    = r_state == S_WR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_RD;
                S_RD:   r_state <= i_sts.emit ? S_DIV : S_WR;
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: if (i_sts.div_done) r_state <= S_OUT;
                S_OUT:  if (!i_sts.out_busy) r_state <= S_WR;
                S_WR:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> r_state == S_OUT) else $error("out load outside OUT");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_WAIT) else $error("divider not awaited");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> r_state == S_RD) else $error("accept lost");
endmodule

// ===== hw/rtl/cdp_offset_stack_top.sv =====
// A new item is accepted only after the last one is through: each passes the read
// and write-back states, and one that yields a result also the divide, wait and
// output states, where it waits on any output stall.
// The divider's one-bit-per-cycle loop sets the read-out rate.
// Reset: synchronous active low; gather state clears, offsets return to 0 and
// 524287; the accumulator memory is not cleared.
// ----------------------------------------------------------------------------
// cdp_offset_stack_top: CDP stack with offset window
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
module cdp_offset_stack_top #(
    parameter int NUM_SAMPLES = 4096,
    parameter int MAX_FOLD    = 255,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [19:0]            i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_operation,
    input  logic [23:0]            i_cdp_number,
    input  logic signed [19:0]     i_trace_offset,
    input  logic [11:0]            i_sample_index,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [23:0]            o_stack_cdp,
    output logic [7:0]             o_stack_fold,
    output logic [11:0]            o_out_index,
    output logic signed [SAMPLE_BITS-1:0] o_stack_value,
    output logic                   o_out_last
);
    cdps_pkg::t_cmd    w_cmd;
    cdps_pkg::t_status w_sts;

    cdps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    cdps_datapath #(.NUM_SAMPLES(NUM_SAMPLES), .MAX_FOLD(MAX_FOLD),
                    .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_cdp_number(i_cdp_number),
        .i_trace_offset(i_trace_offset), .i_sample_index(i_sample_index),
        .i_sample_value(i_sample_value), .i_last_sample(i_last_sample),
        .o_valid(o_valid), .i_stall(i_stall), .o_stack_cdp(o_stack_cdp),
        .o_stack_fold(o_stack_fold), .o_out_index(o_out_index),
        .o_stack_value(o_stack_value), .o_out_last(o_out_last)
    );
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the CDP offset stack
// Drives trace gathers and flush passes through the input channel, predicts
// the stacked read-out per item and checks every result field by field while
// both channels idle and stall at random over several offset windows.
// ----------------------------------------------------------------------------

class stack_scoreboard;
    localparam int NS = 4096;
    localparam int MF = 255;

    logic signed [19:0] lo_off, hi_off;
    logic signed [31:0] acc [NS];
    logic [23:0] cur_cdp, old_cdp;
    logic        gather_open, in_drain, included;
    int          fold, old_fold;

    logic [68:0] pending [$];
    int          errors;
    int          seen;

    function new();
        reset();
        errors = 0;
        seen = 0;
    endfunction

    function void reset();
        lo_off = 20'sd0;
        hi_off = 20'sd524287;
        cur_cdp = '0;
        old_cdp = '0;
        gather_open = 0;
        in_drain = 0;
        included = 0;
        fold = 0;
        old_fold = 0;
        foreach (acc[i]) acc[i] = 0;
    endfunction

    function void set_reg(bit idx, logic [19:0] v);
        if (idx == 1'b0) lo_off = v;
        else hi_off = v;
    endfunction

    function logic signed [31:0] sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function void push_mean(logic [23:0] c, int f, int idx, bit last);
        longint q;
        logic [23:0] v;
        q = longint'(acc[idx]) / f;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        v = q[23:0];
        pending.push_back({c, f[7:0], idx[11:0], v, last});
    endfunction

    function void note_item(bit op, logic [23:0] c, logic signed [19:0] off,
                            logic [11:0] idx, logic signed [23:0] val, bit last);
        if (!op) begin
            if (idx == 0) begin
                if (!gather_open || c != cur_cdp) begin
                    old_cdp = cur_cdp;
                    old_fold = gather_open ? fold : 0;
                    in_drain = 1;
                    cur_cdp = c;
                    gather_open = 1;
                    fold = 0;
                end
                included = off >= lo_off && off <= hi_off && fold < MF;
                if (included) fold++;
            end
            if (gather_open) begin
                if (in_drain) begin
                    if (old_fold != 0) push_mean(old_cdp, old_fold, idx, last);
                    acc[idx] = included ? 32'(val) : 32'sd0;
                end else if (included) begin
                    acc[idx] = sat_add(acc[idx], val);
                end
            end
            if (last) in_drain = 0;
        end else begin
            if (gather_open && fold != 0) push_mean(cur_cdp, fold, idx, last);
            if (last) begin
                gather_open = 0;
                fold = 0;
                in_drain = 0;
                included = 0;
            end
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [23:0] c, logic [7:0] f, logic [11:0] idx,
                      logic [23:0] v, logic last);
        logic [68:0] e;
        seen++;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result cdp=%0d idx=%0d", c, idx));
        end else begin
            e = pending.pop_front();
            if (e[68:45] !== c) report($sformatf("cdp %0d exp %0d", c, e[68:45]));
            if (e[44:37] !== f) report($sformatf("fold %0d exp %0d", f, e[44:37]));
            if (e[36:25] !== idx) report($sformatf("index %0d exp %0d", idx, e[36:25]));
            if (e[24:1] !== v)
                report($sformatf("value %0d exp %0d idx %0d", $signed(v),
                                 $signed(e[24:1]), idx));
            if (e[0] !== last) report($sformatf("last %0b exp %0b", last, e[0]));
        end
    endtask
endclass

module tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_addr = 0;
    logic [19:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_operation = 0;
    logic [23:0] i_cdp_number = '0;
    logic signed [19:0] i_trace_offset = '0;
    logic [11:0] i_sample_index = '0;
    logic signed [23:0] i_sample_value = '0;
    logic        i_last_sample = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [23:0] o_stack_cdp;
    logic [7:0]  o_stack_fold;
    logic [11:0] o_out_index;
    logic signed [23:0] o_stack_value;
    logic        o_out_last;

    localparam bit REG_MIN = 1'b0;
    localparam bit REG_MAX = 1'b1;
    localparam bit OP_SAMPLE = 1'b0;
    localparam bit OP_FLUSH = 1'b1;
    localparam longint CYCLE_LIMIT = 3000000;

    stack_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  items_sent = 0;
    int  flushes = 0;
    longint cycles = 0;

    cdp_offset_stack_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_stack_cdp, o_stack_fold, o_out_index, o_stack_value,
                            o_out_last);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task send_item(bit op, logic [23:0] c, logic signed [19:0] off, logic [11:0] idx,
                   logic signed [23:0] val, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_operation <= op;
        i_cdp_number <= c;
        i_trace_offset <= off;
        i_sample_index <= idx;
        i_sample_value <= val;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(op, c, off, idx, val, last);
        items_sent++;
        if (op == OP_FLUSH) flushes++;
    endtask

    task idle_wait();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task write_reg(bit idx, logic [19:0] v);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    function logic signed [23:0] rand_val();
        case ($urandom_range(3))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // a trace of len samples at indexes 0..len-1
    task send_trace(logic [23:0] c, logic signed [19:0] off, int len);
        for (int k = 0; k < len; k++)
            send_item(OP_SAMPLE, c, off, k[11:0], rand_val(), k == len - 1);
    endtask

    task send_flush(int len);
        for (int k = 0; k < len; k++)
            send_item(OP_FLUSH, 24'($urandom), 20'($urandom), k[11:0], 24'($urandom),
                      k == len - 1);
    endtask

    initial begin
        int len;
        int n;
        logic [23:0] c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: full-scale samples, window edges, gather change, flush
        write_reg(REG_MIN, 20'h80000);
        write_reg(REG_MAX, 20'h7ffff);
        send_item(OP_FLUSH, 0, 0, 0, 0, 1);
        send_item(OP_SAMPLE, 24'hffffff, 20'sh80000, 0, 24'sh7fffff, 0);
        send_item(OP_SAMPLE, 24'h0, 20'sh0, 1, 24'sh800000, 0);
        send_item(OP_SAMPLE, 24'h0, 20'sh0, 2, 24'sh7fffff, 1);
        send_item(OP_SAMPLE, 24'hffffff, 20'sh7ffff, 0, 24'sh7fffff, 0);
        send_item(OP_SAMPLE, 24'hffffff, 20'sh7ffff, 1, 24'sh800000, 0);
        send_item(OP_SAMPLE, 24'hffffff, 20'sh7ffff, 2, -24'sd3, 1);
        send_item(OP_SAMPLE, 24'hffffff, 20'sh7ffff, 2, 24'sd5, 1);
        send_item(OP_SAMPLE, 24'h000001, 20'sd0, 0, 24'sd7, 0);
        send_item(OP_SAMPLE, 24'h000001, 20'sd0, 1, -24'sd7, 0);
        send_item(OP_SAMPLE, 24'h000001, 20'sd0, 2, 24'sd1, 1);
        send_flush(3);
        idle_wait();
        write_reg(REG_MIN, 20'sd10);
        write_reg(REG_MAX, -20'sd10);
        send_trace(24'h5, 20'sd0, 3);
        send_trace(24'h6, 20'sd0, 3);
        send_flush(3);
        idle_wait();

        // first trace of a new gather sets every index the random part uses
        send_trace(24'h9, 20'sd0, 6);
        send_flush(1);
        idle_wait();

        // random: short gathers, mostly well-formed traces
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            if (ph == 4) begin
                write_reg(REG_MIN, 20'h80000);
                write_reg(REG_MAX, 20'h7ffff);
            end else if (ph != 0) begin
                write_reg(REG_MIN, 20'(-$urandom_range(300)));
                write_reg(REG_MAX, 20'($urandom_range(300)));
            end
            n = items_sent + 45;
            c = 24'($urandom_range(3));
            while (items_sent < n) begin
                len = $urandom_range(2, 6);
                case ($urandom_range(9))
                    0: send_flush($urandom_range(1, len));
                    1: send_item(OP_SAMPLE, 24'($urandom), 20'($urandom),
                                 12'($urandom_range(1, len - 1)), 24'($urandom),
                                 $urandom_range(1));
                    2: begin
                        c = 24'($urandom);
                        send_trace(c, $urandom_range(0, 1) ? 20'($urandom) : 20'sd5, len);
                    end
                    default: begin
                        if ($urandom_range(3) == 0) c = c + 1;
                        send_trace(c, 20'($signed(20'($urandom_range(0, 600))) - 300), len);
                    end
                endcase
            end
            send_flush(6);
            idle_wait();
        end

        $display("run covered %0d items, %0d flush items, %0d results checked",
                 items_sent, flushes, sb.seen);
        $display("offset windows included extremes, empty and random ranges");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/cdps_pkg.sv
hw/rtl/cdps_div.sv
hw/rtl/cdps_datapath.sv
hw/rtl/cdps_ctrl.sv
hw/rtl/cdp_offset_stack_top.sv
verif/tb.sv
